>>> hw/rtl/pd_pkg.sv
// Shared types, constants and the arctangent table for the polyline densifier.
package pd_pkg;

    localparam int DEF_MAX_STEPS = 63;
    localparam int DEF_FRAC_BITS = 16;
    localparam int COORD_W       = 32;
    localparam int DELTA_W       = COORD_W + 1;
    localparam int RES_W         = 22;
    localparam int HEAD_W        = 16;
    localparam int MUL_W         = 28;
    localparam int CORDIC_ITERS  = 31;
    localparam int ITER_W        = 5;
    localparam int ANGLE_W       = 30;
    localparam logic [RES_W-1:0] RES_RESET = 22'd13107;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQR,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_DIVX,
        ST_DIVX_WAIT,
        ST_DIVY,
        ST_DIVY_WAIT,
        ST_COR,
        ST_COR_WAIT,
        ST_EMIT,
        ST_FINAL
    } pd_state_t;

    // atan(2^-i) in units of pi/2^31, rounded
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/pd_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module pd_divider #(
    parameter int DW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pd_pkg::DELTA_W-1:0]  dividend,
    input  logic [DW-1:0]               divisor,
    output logic                        done,
    output logic [pd_pkg::DELTA_W-1:0]  quotient,
    output logic [DW-1:0]               remainder
);
    import pd_pkg::*;

    localparam int CNT_W = $clog2(DELTA_W);

    logic [DELTA_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [DW-1:0]      div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DW:0]        trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DELTA_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DW'(trial - {1'b0, div_reg});
            quo_next = {quo_reg[DELTA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[DELTA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DELTA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/pd_cordic.sv
// Iterative vectoring CORDIC giving the heading of a segment direction.
module pd_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [pd_pkg::DELTA_W-1:0]  dx,
    input  logic signed [pd_pkg::DELTA_W-1:0]  dy,
    output logic                               done,
    output logic signed [pd_pkg::HEAD_W-1:0]   heading
);
    import pd_pkg::*;

    localparam int XW = DELTA_W + 3;
    localparam int ZW = 34;

    logic signed [XW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg, z_round;
    logic [ITER_W-1:0]    i_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [ZW-1:0] ang;

    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;
    assign ang     = ZW'(signed'({1'b0, atan_lut(i_reg)}));
    assign z_round = z_reg + ZW'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // fold the left half-plane by a quarter turn
            if (dx < 0)
            begin
                if (dy >= 0)
                begin
                    x_reg <= XW'(dy);
                    y_reg <= -XW'(dx);
                    z_reg <= ZW'(64'sd1 <<< 30);
                end
                else
                begin
                    x_reg <= -XW'(dy);
                    y_reg <= XW'(dx);
                    z_reg <= -ZW'(64'sd1 <<< 30);
                end
            end
            else
            begin
                x_reg <= XW'(dx);
                y_reg <= XW'(dy);
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
        end
    end

    assign done    = done_reg;
    assign heading = z_round[HEAD_W+15:16];

endmodule

>>> hw/rtl/polyline_densifier.sv
// Polyline densifier top level: sequencer, step search and pose emission.
//
// Vertices enter on the s_ stream (tdata = point_x, point_y; tlast = path_last)
// and evenly spaced poses leave on the m_ stream. The spacing register is
// written through the cfg channel, which is always ready; write it only while
// the block is idle. s_tready is high only while the sequencer is idle.
// After the accepting cycle a segment passes through squaring on the shared
// multiplier and a step search (both skipped after the first square when either
// axis spans 2^28 or more), two divisions on the serial divider, the CORDIC and
// the emission of its poses.
// A vertex ending the polyline adds a final pose, unless it is also its first vertex.
// The first vertex of a polyline, or a repeated vertex, starts no segment.
// Results sit in an output register; while the receiver stalls the sequencer
// waits with the next pose and the input stays blocked.
// Reset clears the polyline state and returns the spacing to 0.2 m.
// m_tlast marks the last pose caused by one vertex.
module polyline_densifier #(
    parameter int MAX_STEPS = pd_pkg::DEF_MAX_STEPS,
    parameter int FRAC_BITS = pd_pkg::DEF_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // point_x, point_y
    input  logic                        s_tlast,   // path_last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [79:0]                 m_tdata,   // pose_x, pose_y, heading
    output logic                        m_tlast,   // run_last
    output logic [1:0]                  m_tuser,   // path_end, steps_capped
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pd_pkg::RES_W-1:0]    cfg_data   // step_resolution
);
    import pd_pkg::*;

    localparam int KW   = $clog2(MAX_STEPS + 2);
    localparam int LW0  = 2 * RES_W + 2 * KW + 2;
    localparam int LW   = (LW0 > 58) ? LW0 : 58;
    localparam int QW   = DELTA_W + 1;
    localparam logic [RES_W-1:0] RES_MIN = RES_W'((64'd1 << FRAC_BITS) / 1000);
    localparam logic [RES_W-1:0] RES_DEF = RES_W'((64'd2 << FRAC_BITS) / 10);

    pd_state_t state_reg, state_next;

    logic [RES_W-1:0]          res_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, bx_reg, by_reg;
    logic                      have_prev_reg, any_reg, last_reg, big_reg;
    logic [HEAD_W-1:0]         last_head_reg, head_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg, dxw, dyw;
    logic [DELTA_W-1:0]        adx, ady, adxw, adyw;
    logic [LW-1:0]             l2_reg, kk_reg, t_reg, r2_reg;
    logic [KW-1:0]             k_reg, steps_reg, s_reg;
    logic                      capped_reg;
    logic signed [QW-1:0]      qdx_reg, qdy_reg, qx_reg, qy_reg;
    logic [KW-1:0]             rdx_reg, rdy_reg, rx_reg, ry_reg;
    logic [RES_W-1:0]          res_eff;
    logic [MUL_W-1:0]          mul_a;
    logic [2*MUL_W-1:0]        prod;
    logic                      acc, out_free, load_pose, load_final;
    logic                      div_start, cor_start, div_done, cor_done;
    logic [DELTA_W-1:0]        div_in, div_q;
    logic [KW-1:0]             div_r;
    logic signed [HEAD_W-1:0]  cor_head;
    logic signed [QW-1:0]      fq;
    logic [KW-1:0]             fr;
    logic [KW:0]               rx_sum, ry_sum;
    logic                      pose_done;

    logic                      m_valid_reg, m_last_reg, m_end_reg, m_cap_reg;
    logic [COORD_W-1:0]        m_x_reg, m_y_reg;
    logic [HEAD_W-1:0]         m_h_reg;

    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign dxw  = DELTA_W'(signed'(s_tdata[31:0])) - DELTA_W'(prev_x_reg);
    assign dyw  = DELTA_W'(signed'(s_tdata[63:32])) - DELTA_W'(prev_y_reg);
    assign adxw = dxw[DELTA_W-1] ? DELTA_W'(-dxw) : DELTA_W'(dxw);
    assign adyw = dyw[DELTA_W-1] ? DELTA_W'(-dyw) : DELTA_W'(dyw);
    assign adx  = dx_reg[DELTA_W-1] ? DELTA_W'(-dx_reg) : DELTA_W'(dx_reg);
    assign ady  = dy_reg[DELTA_W-1] ? DELTA_W'(-dy_reg) : DELTA_W'(dy_reg);

    assign res_eff   = (res_reg <= RES_MIN) ? RES_DEF : res_reg;
    assign pose_done = (s_reg == steps_reg - 1'b1);

    // shared squaring multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQX:  mul_a = adx[MUL_W-1:0];
            ST_SQY:  mul_a = ady[MUL_W-1:0];
            default: mul_a = MUL_W'(res_eff);
        endcase
        prod = mul_a * mul_a;
    end

    assign div_in = (state_reg == ST_DIVY) ? ady : adx;

    pd_divider #(.DW(KW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_in),
        .divisor   (steps_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    pd_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .done    (cor_done),
        .heading (cor_head)
    );

    // floor correction of the unsigned quotient for the active axis
    always_comb
    begin
        logic neg;
        neg = (state_reg == ST_DIVY_WAIT) ? dy_reg[DELTA_W-1] : dx_reg[DELTA_W-1];
        if (!neg)
        begin
            fq = QW'(div_q);
            fr = div_r;
        end
        else if (div_r == '0)
        begin
            fq = -QW'(div_q);
            fr = '0;
        end
        else
        begin
            fq = -QW'(div_q) - QW'(1);
            fr = steps_reg - div_r;
        end
    end

    assign rx_sum = {1'b0, rx_reg} + {1'b0, rdx_reg};
    assign ry_sum = {1'b0, ry_reg} + {1'b0, rdy_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && have_prev_reg)
                begin
                    if (dxw != '0 || dyw != '0)
                        state_next = ST_SQX;
                    else if (s_tlast)
                        state_next = ST_FINAL;
                end
            end
            ST_SQX:       state_next = big_reg ? ST_DIVX : ST_SQY;
            ST_SQY:       state_next = ST_SQR;
            ST_SQR:       state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (kk_reg > l2_reg || k_reg == KW'(MAX_STEPS + 1))
                    state_next = ST_DIVX;
            end
            ST_DIVX:      state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (div_done) state_next = ST_DIVY;
            ST_DIVY:      state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (div_done) state_next = ST_COR;
            ST_COR:       state_next = ST_COR_WAIT;
            ST_COR_WAIT:  if (cor_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free && pose_done)
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL:     if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = 1'b0;
        div_start  = 1'b0;
        cor_start  = 1'b0;
        load_pose  = 1'b0;
        load_final = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready   = 1'b1;
            ST_DIVX:  div_start  = 1'b1;
            ST_DIVY:  div_start  = 1'b1;
            ST_COR:   cor_start  = 1'b1;
            ST_EMIT:  load_pose  = out_free;
            ST_FINAL: load_final = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_reg       <= RES_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            last_head_reg <= '0;
            any_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                res_reg <= cfg_data;

            if (acc)
            begin
                if (s_tlast && !(have_prev_reg && (dxw != '0 || dyw != '0)))
                begin
                    if (!have_prev_reg)
                    begin
                        prev_x_reg    <= '0;
                        prev_y_reg    <= '0;
                        have_prev_reg <= 1'b0;
                        last_head_reg <= '0;
                        any_reg       <= 1'b0;
                    end
                end
                else if (!s_tlast && !(have_prev_reg && (dxw != '0 || dyw != '0)))
                begin
                    prev_x_reg    <= signed'(s_tdata[31:0]);
                    prev_y_reg    <= signed'(s_tdata[63:32]);
                    have_prev_reg <= 1'b1;
                end
            end

            if (load_pose && pose_done)
            begin
                last_head_reg <= head_reg;
                any_reg       <= 1'b1;
                if (!last_reg)
                begin
                    prev_x_reg <= bx_reg;
                    prev_y_reg <= by_reg;
                end
            end

            if (load_final)
            begin
                prev_x_reg    <= '0;
                prev_y_reg    <= '0;
                have_prev_reg <= 1'b0;
                last_head_reg <= '0;
                any_reg       <= 1'b0;
            end

            if (load_pose || load_final)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // segment datapath
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            bx_reg   <= signed'(s_tdata[31:0]);
            by_reg   <= signed'(s_tdata[63:32]);
            last_reg <= s_tlast;
            dx_reg   <= dxw;
            dy_reg   <= dyw;
            big_reg  <= (adxw >= (DELTA_W'(1) << 28)) || (adyw >= (DELTA_W'(1) << 28));
        end

        case (state_reg)
            ST_SQX:
            begin
                l2_reg     <= LW'(prod);
                steps_reg  <= KW'(MAX_STEPS);
                capped_reg <= big_reg;
            end
            ST_SQY: l2_reg <= l2_reg + LW'(prod);
            ST_SQR: r2_reg <= LW'(prod);
            ST_SCAN_INIT:
            begin
                kk_reg     <= r2_reg;
                t_reg      <= (r2_reg << 1) + r2_reg;
                k_reg      <= KW'(1);
                steps_reg  <= KW'(1);
                capped_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                if (kk_reg <= l2_reg)
                begin
                    if (k_reg == KW'(MAX_STEPS + 1))
                        capped_reg <= 1'b1;
                    else
                    begin
                        steps_reg <= k_reg;
                        k_reg     <= k_reg + 1'b1;
                        kk_reg    <= kk_reg + t_reg;
                        t_reg     <= t_reg + (r2_reg << 1);
                    end
                end
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    qdx_reg <= fq;
                    rdx_reg <= fr;
                end
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    qdy_reg <= fq;
                    rdy_reg <= fr;
                end
            end
            ST_COR_WAIT:
            begin
                if (cor_done)
                begin
                    head_reg <= cor_head;
                    qx_reg   <= '0;
                    qy_reg   <= '0;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    s_reg    <= '0;
                end
            end
            ST_EMIT:
            begin
                if (load_pose)
                begin
                    s_reg <= s_reg + 1'b1;
                    if (rx_sum >= {1'b0, steps_reg})
                    begin
                        rx_reg <= KW'(rx_sum - {1'b0, steps_reg});
                        qx_reg <= qx_reg + qdx_reg + QW'(1);
                    end
                    else
                    begin
                        rx_reg <= rx_sum[KW-1:0];
                        qx_reg <= qx_reg + qdx_reg;
                    end
                    if (ry_sum >= {1'b0, steps_reg})
                    begin
                        ry_reg <= KW'(ry_sum - {1'b0, steps_reg});
                        qy_reg <= qy_reg + qdy_reg + QW'(1);
                    end
                    else
                    begin
                        ry_reg <= ry_sum[KW-1:0];
                        qy_reg <= qy_reg + qdy_reg;
                    end
                end
            end
            default: ;
        endcase

        if (load_pose)
        begin
            m_x_reg    <= prev_x_reg + qx_reg[COORD_W-1:0];
            m_y_reg    <= prev_y_reg + qy_reg[COORD_W-1:0];
            m_h_reg    <= head_reg;
            m_last_reg <= pose_done && !last_reg;
            m_end_reg  <= 1'b0;
            m_cap_reg  <= capped_reg;
        end
        else if (load_final)
        begin
            m_x_reg    <= bx_reg;
            m_y_reg    <= by_reg;
            m_h_reg    <= any_reg ? last_head_reg : '0;
            m_last_reg <= 1'b1;
            m_end_reg  <= 1'b1;
            m_cap_reg  <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_h_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_cap_reg, m_end_reg};

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && !m_tuser[1])
        else $error("final pose without run end or with capped flag");

    a_steps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> steps_reg != '0 && s_reg < steps_reg)
        else $error("pose index outside step count");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> rx_reg < steps_reg && ry_reg < steps_reg)
        else $error("interpolation remainder out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> !$past(load_pose || load_final))
        else $error("output register overwritten while stalled");

endmodule

>>> test/tb_top.sv
// Testbench for the polyline densifier: directed and random polylines checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    import pd_pkg::*;

    localparam int MAXS     = 63;
    localparam int RES_MINV = 65;
    localparam int RES_DEFV = 13107;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic        rl;
        logic        pe;
        logic        cp;
    } pose_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [79:0]       m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RES_W-1:0]  cfg_data;

    polyline_densifier uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor state
    logic [RES_W-1:0]  res_q;
    logic signed [31:0] prv_x, prv_y;
    logic              prv_ok;
    logic [15:0]       prv_hd;
    logic              prv_any;

    pose_t expected_poses[$];
    int    n_err;
    int    n_sent;
    int    n_got;
    int    idle_cnt;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] seg_heading(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        longint tab[31];
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                10, 5, 3, 1, 1};
        x = dx;
        y = dy;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 64'sd1 << 30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -(64'sd1 << 30);
            end
        end
        for (int i = 0; i < 31; i++)
        begin
            xs = sra(x, i);
            ys = sra(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += tab[i];
            end
            else
            begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return 16'(sra(z + 32768, 16));
    endfunction

    function automatic longint fdiv(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -(((-num) + den - 1) / den);
    endfunction

    task automatic predict_vertex(logic signed [31:0] bx, logic signed [31:0] by, logic lst);
        longint dx, dy, res, adx, ady, l2, r2, steps;
        logic   big, capped;
        logic [15:0] h;
        pose_t p;
        int n0;
        n0 = expected_poses.size();
        if (prv_ok)
        begin
            dx = longint'(bx) - longint'(prv_x);
            dy = longint'(by) - longint'(prv_y);
            if (dx != 0 || dy != 0)
            begin
                res = res_q;
                if (res <= RES_MINV)
                    res = RES_DEFV;
                adx = dx < 0 ? -dx : dx;
                ady = dy < 0 ? -dy : dy;
                big = adx >= (64'sd1 << 28) || ady >= (64'sd1 << 28);
                l2 = big ? 0 : adx * adx + ady * ady;
                r2 = res * res;
                steps = 1;
                capped = 1'b0;
                for (int k = 1; k <= MAXS + 1; k++)
                begin
                    if (big || longint'(k * k) * r2 <= l2)
                    begin
                        if (k > MAXS)
                            capped = 1'b1;
                        else
                            steps = k;
                    end
                    else
                        break;
                end
                h = seg_heading(dx, dy);
                for (longint s = 0; s < steps; s++)
                begin
                    p.px = 32'(longint'(prv_x) + fdiv(s * dx, steps));
                    p.py = 32'(longint'(prv_y) + fdiv(s * dy, steps));
                    p.hd = h;
                    p.rl = 1'b0;
                    p.pe = 1'b0;
                    p.cp = capped;
                    expected_poses.insert(expected_poses.size(), p);
                end
                prv_hd = h;
                prv_any = 1'b1;
            end
            if (lst)
            begin
                p.px = bx;
                p.py = by;
                p.hd = prv_any ? prv_hd : 16'd0;
                p.rl = 1'b0;
                p.pe = 1'b1;
                p.cp = 1'b0;
                expected_poses.insert(expected_poses.size(), p);
            end
        end
        if (expected_poses.size() > n0)
            expected_poses[$].rl = 1'b1;
        if (lst)
        begin
            prv_x = 0; prv_y = 0; prv_ok = 0; prv_hd = 0; prv_any = 0;
        end
        else
        begin
            prv_x = bx; prv_y = by; prv_ok = 1'b1;
        end
    endtask

    // s_tvalid stays high after a transaction until the next gap or a pause
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y, logic lst);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_vertex(x, y, lst);
        n_sent++;
    endtask

    // settle fully, then write the spacing register
    task automatic write_resolution(logic [RES_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        res_q = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_pose();
        pose_t got, exp_p;
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[79:64], m_tlast, m_tuser[0], m_tuser[1]};
        n_got++;
        if (expected_poses.size() == 0)
        begin
            n_err++;
            if (n_err <= 10)
                $display("unexpected pose %h", got);
            return;
        end
        exp_p = expected_poses.pop_front();
        if (got !== exp_p)
        begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch: x %h/%h y %h/%h hd %h/%h last %b/%b end %b/%b cap %b/%b",
                         exp_p.px, got.px, exp_p.py, got.py, exp_p.hd, got.hd,
                         exp_p.rl, got.rl, exp_p.pe, got.pe, exp_p.cp, got.cp);
        end
    endtask

    // receiver stalls and result checking
    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (wait_n != 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_pose();
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'sh7fffffff - $urandom_range(0, 3);
            default: return 32'sh80000000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic test_directed();
        send_vertex(0, 0, 1);                       // one-point polyline
        send_vertex(0, 0, 0);
        send_vertex(0, 0, 0);                       // zero-length segment
        send_vertex(0, 0, 1);                       // zero-length end, final pose only
        send_vertex(32'sh10000, 0, 0);
        send_vertex(32'sh30000, 32'sh20000, 0);
        send_vertex(32'sh30000, 32'sh20000, 0);
        send_vertex(-32'sh10000, 32'sh20000, 0);   // heading pi
        send_vertex(-32'sh10000, -32'sh50000, 1);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 0);
        send_vertex(32'sh80000000, 32'sh80000000, 0);   // huge, capped
        send_vertex(32'sh7fffffff, 32'sh80000000, 1);
        send_vertex(5, 7, 0);
        send_vertex(4, 6, 1);                       // tiny segment, one step
    endtask

    task automatic test_resolution(logic [RES_W-1:0] v);
        write_resolution(v);
        send_vertex(0, 0, 0);
        send_vertex(32'sh40000, -32'sh30000, 0);
        send_vertex(32'sh1000, 32'sh2000, 1);
    endtask

    task automatic test_random(int n);
        int len;
        logic signed [31:0] x, y;
        while (n > 0)
        begin
            len = $urandom_range(1, 8);
            x = rnd_coord();
            y = rnd_coord();
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    x = rnd_coord();
                    y = rnd_coord();
                end
                else if ($urandom_range(0, 9) != 0)
                begin
                    x = x + 32'($signed($urandom_range(0, 400000)) - 200000);
                    y = y + 32'($signed($urandom_range(0, 400000)) - 200000);
                end
                send_vertex(x, y, (i == len - 1) || ($urandom_range(0, 19) == 0));
                n--;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        res_q = RES_RESET;
        prv_x = 0; prv_y = 0; prv_ok = 0; prv_hd = 0; prv_any = 0;
        n_err = 0; n_sent = 0; n_got = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_resolution(22'd0);
        test_resolution(22'd65);
        test_resolution(22'd66);
        test_resolution(22'h3fffff);
        test_resolution(22'd1000);
        test_random(140);
        write_resolution(22'd4000);
        test_random(140);
        write_resolution(22'd20000);
        test_random(120);
        s_tvalid <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d vertices over eight spacing settings, checked %0d poses, %0d errors",
                 n_sent, n_got, n_err);
        if (n_err == 0 && expected_poses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> polyline_densifier.f
hw/rtl/pd_pkg.sv
hw/rtl/pd_divider.sv
hw/rtl/pd_cordic.sv
hw/rtl/polyline_densifier.sv
test/tb_top.sv
